[rtl/jsu_pkg.sv]
// Shared types, codes and helpers for the JSON string unescaper.
// No dependencies; imported by every module of the block.
package jsu_pkg;

  localparam int unsigned MAX_OUT = 3;

  // decoder mode codes; values 6 and 7 behave as plain text
  localparam logic [2:0] MODE_PLAIN = 3'd0;
  localparam logic [2:0] MODE_ESC   = 3'd1;
  localparam logic [2:0] MODE_HEX1  = 3'd2;
  localparam logic [2:0] MODE_HEX4  = 3'd5;

  // result status codes
  localparam logic [2:0] ST_BYTE   = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_BADESC = 3'd2;
  localparam logic [2:0] ST_BADHEX = 3'd3;
  localparam logic [2:0] ST_EOF    = 3'd4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [15:0] CP_1B_MAX = 16'h007f;
  localparam logic [15:0] CP_2B_MAX = 16'h07ff;
  localparam logic [7:0]  UTF_LEAD2 = 8'hc0;
  localparam logic [7:0]  UTF_LEAD3 = 8'he0;
  localparam logic [7:0]  UTF_CONT  = 8'h80;
  localparam logic [5:0]  UTF_MASK  = 6'h3f;

  // all results caused by one input item
  typedef struct packed {
    logic [1:0]             cnt;     // number of results, 0..3
    logic [2:0]             status;
    logic [MAX_OUT-1:0][7:0] bytes;  // element 0 goes out first
  } jsu_bundle_t;

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

[rtl/jsu_decode.sv]
// Escape decoder: mode and hex accumulator state plus the per-item result bundle.
// Depends on jsu_pkg.
module jsu_decode import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,     // registered item is consumed this cycle
  input  logic        kind,     // 1 = end of input
  input  logic [7:0]  in_byte,
  output jsu_bundle_t bundle
);

  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [4:0]  hd;
  logic [15:0] cp;

  assign hd = hex_digit(in_byte);
  assign cp = {acc_r[11:0], hd[3:0]};

  always_comb begin
    mode_nxt      = mode_r;
    acc_nxt       = acc_r;
    bundle.cnt    = 2'd0;
    bundle.status = ST_BYTE;
    bundle.bytes  = '0;
    if (kind) begin
      mode_nxt      = MODE_PLAIN;
      acc_nxt       = 16'd0;
      bundle.cnt    = 2'd1;
      bundle.status = ST_EOF;
    end else begin
      case (mode_r)
        MODE_ESC: begin
          mode_nxt   = MODE_PLAIN;
          bundle.cnt = 2'd1;
          case (in_byte)
            CH_QUOTE, CH_BSL, CH_SLASH: bundle.bytes[0] = in_byte;
            CH_B: bundle.bytes[0] = 8'h08;
            CH_F: bundle.bytes[0] = 8'h0c;
            CH_N: bundle.bytes[0] = 8'h0a;
            CH_R: bundle.bytes[0] = 8'h0d;
            CH_T: bundle.bytes[0] = 8'h09;
            CH_U: begin
              mode_nxt   = MODE_HEX1;
              acc_nxt    = 16'd0;
              bundle.cnt = 2'd0;
            end
            default: begin
              acc_nxt       = 16'd0;
              bundle.status = ST_BADESC;
            end
          endcase
        end
        default: begin
          if (mode_r inside {[MODE_HEX1:MODE_HEX4]}) begin
            if (!hd[4]) begin
              mode_nxt      = MODE_PLAIN;
              acc_nxt       = 16'd0;
              bundle.cnt    = 2'd1;
              bundle.status = ST_BADHEX;
            end else if (mode_r == MODE_HEX4) begin
              mode_nxt = MODE_PLAIN;
              acc_nxt  = 16'd0;
              if (cp <= CP_1B_MAX) begin
                bundle.cnt      = 2'd1;
                bundle.bytes[0] = cp[7:0];
              end else if (cp <= CP_2B_MAX) begin
                bundle.cnt      = 2'd2;
                bundle.bytes[0] = UTF_LEAD2 | {3'b000, cp[10:6]};
                bundle.bytes[1] = UTF_CONT | {2'b00, cp[5:0] & UTF_MASK};
              end else begin
                bundle.cnt      = 2'd3;
                bundle.bytes[0] = UTF_LEAD3 | {4'b0000, cp[15:12]};
                bundle.bytes[1] = UTF_CONT | {2'b00, cp[11:6] & UTF_MASK};
                bundle.bytes[2] = UTF_CONT | {2'b00, cp[5:0] & UTF_MASK};
              end
            end else begin
              mode_nxt = mode_r + 3'd1;
              acc_nxt  = cp;
            end
          end else begin
            // plain text, including the unused mode codes
            mode_nxt = MODE_PLAIN;
            if (in_byte == CH_QUOTE) begin
              acc_nxt       = 16'd0;
              bundle.cnt    = 2'd1;
              bundle.status = ST_DONE;
            end else if (in_byte == CH_BSL) begin
              mode_nxt = MODE_ESC;
            end else begin
              bundle.cnt      = 2'd1;
              bundle.bytes[0] = in_byte;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      acc_r  <= 16'd0;
    end else if (take) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

[rtl/jsu_emit.sv]
// Result register: holds one item's bundle and sends its results one per request.
// Depends on jsu_pkg.
module jsu_emit import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,       // take a new bundle
  input  jsu_bundle_t bundle,
  output logic        can_load,   // free now or freed by this cycle's request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  logic [1:0]               left_r;
  logic [1:0]               idx_r;
  logic [2:0]               status_r;
  logic [MAX_OUT-1:0][7:0]  bytes_r;
  logic                     fire;

  assign out_tvalid = (left_r != 2'd0);
  assign fire       = out_tvalid && out_tready;
  assign can_load   = (left_r == 2'd0) || (left_r == 2'd1 && out_tready);
  assign out_tdata  = bytes_r[idx_r];
  assign out_tuser  = status_r;
  assign out_tlast  = (left_r == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 2'd0;
      idx_r  <= 2'd0;
    end else if (load) begin
      left_r <= bundle.cnt;
      idx_r  <= 2'd0;
    end else if (fire) begin
      left_r <= left_r - 2'd1;
      idx_r  <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= bundle.status;
      bytes_r  <= bundle.bytes;
    end
  end

endmodule

[rtl/json_string_unescape.sv]
// Top level of the JSON string unescaper: input register, decoder, result register.
// Depends on jsu_pkg, jsu_decode and jsu_emit.
//
//   channel  | direction | tdata          | tuser          | tlast
//   in_      | sink      | [7:0] in_byte  | [0] kind       | -
//   out_     | source    | [7:0] out_byte | [2:0] status   | last
//
// Each request passes an input register, the combinational decode logic and
// the result register, which drives the output channel.
// One input item per cycle is sustained while items give one result or none
// and out_tready stays high; a \u escape giving two or three UTF-8 bytes holds
// the input while the result register drains.
// rst_n is synchronous, active low: decoder returns to plain text, both
// registers empty. Back pressure on out_tready stalls the result register,
// then the input register, then in_tready.
module json_string_unescape import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] kind: 1 = end of input
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [2:0] status
  output logic       out_tlast   // last result of an input request
);

  logic        in_vld_r;
  logic        kind_r;
  logic [7:0]  byte_r;
  logic        can_load;
  logic        take;
  jsu_bundle_t bundle;

  // registered item moves into decode when the result register can accept its bundle
  assign take      = in_vld_r && can_load;
  assign in_tready = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r <= in_tuser;
      byte_r <= in_tdata;
    end
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .kind    (kind_r),
    .in_byte (byte_r),
    .bundle  (bundle)
  );

  jsu_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take),
    .bundle     (bundle),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[test/json_unescape_checker.sv]
// Checker for json_string_unescape: watches both stream channels, decodes each
// accepted request on its own and compares every accepted result in order.
// Depends on jsu_pkg for status, mode and character codes.
module json_unescape_checker import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] kind: 1 = end of input
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_byte
  input  logic [2:0] out_tuser,  // [2:0] status
  input  logic       out_tlast,
  output int         fail_cnt,
  output int         results_owed
);

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] status;
    logic       last;
  } result_t;

  result_t    owed_q[$];
  result_t    want;
  logic [2:0] dec_mode;
  logic [15:0] cp_acc;

  // {ok, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  task automatic owe(input logic [7:0] d, input logic [2:0] s, input logic l);
    owed_q.insert(owed_q.size(), {d, s, l});
  endtask

  task automatic close_string(input logic [2:0] s);
    dec_mode = MODE_PLAIN;
    cp_acc   = '0;
    owe(8'h00, s, 1'b1);
  endtask

  task automatic emit_utf8(input logic [15:0] cp);
    if (cp <= CP_1B_MAX) begin
      owe(cp[7:0], ST_BYTE, 1'b1);
    end else if (cp <= CP_2B_MAX) begin
      owe(UTF_LEAD2 | {3'b000, cp[10:6]}, ST_BYTE, 1'b0);
      owe(UTF_CONT | {2'b00, cp[5:0] & UTF_MASK}, ST_BYTE, 1'b1);
    end else begin
      owe(UTF_LEAD3 | {4'h0, cp[15:12]}, ST_BYTE, 1'b0);
      owe(UTF_CONT | {2'b00, cp[11:6] & UTF_MASK}, ST_BYTE, 1'b0);
      owe(UTF_CONT | {2'b00, cp[5:0] & UTF_MASK}, ST_BYTE, 1'b1);
    end
  endtask

  task automatic decode_request(input logic k, input logic [7:0] c);
    logic [4:0]  hv;
    logic [15:0] cp;
    logic [7:0]  esc_char;
    logic        esc_ok;
    esc_ok   = 1'b1;
    esc_char = c;
    if (k) begin
      close_string(ST_EOF);
    end else if (dec_mode == MODE_ESC) begin
      case (c)
        CH_QUOTE, CH_BSL, CH_SLASH: esc_char = c;
        CH_B: esc_char = 8'h08;
        CH_F: esc_char = 8'h0c;
        CH_N: esc_char = 8'h0a;
        CH_R: esc_char = 8'h0d;
        CH_T: esc_char = 8'h09;
        CH_U: begin
          esc_ok   = 1'b0;
          dec_mode = MODE_HEX1;
          cp_acc   = '0;
        end
        default: begin
          esc_ok = 1'b0;
          close_string(ST_BADESC);
        end
      endcase
      if (esc_ok) begin
        dec_mode = MODE_PLAIN;
        owe(esc_char, ST_BYTE, 1'b1);
      end
    end else if (dec_mode >= MODE_HEX1 && dec_mode <= MODE_HEX4) begin
      hv = hex_val(c);
      if (!hv[4]) begin
        close_string(ST_BADHEX);
      end else begin
        cp = {cp_acc[11:0], hv[3:0]};
        if (dec_mode == MODE_HEX4) begin
          dec_mode = MODE_PLAIN;
          cp_acc   = '0;
          emit_utf8(cp);
        end else begin
          cp_acc   = cp;
          dec_mode = dec_mode + 3'd1;
        end
      end
    end else if (c == CH_QUOTE) begin
      close_string(ST_DONE);
    end else if (c == CH_BSL) begin
      dec_mode = MODE_ESC;
    end else begin
      // plain text, and the modes that cannot arise
      dec_mode = MODE_PLAIN;
      owe(c, ST_BYTE, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_q.delete();
      dec_mode = MODE_PLAIN;
      cp_acc   = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_request(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: out_byte %02h status %0d last %0b",
                 out_tdata, out_tuser, out_tlast);
          fail_cnt++;
        end else begin
          want = owed_q.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_tdata);
            fail_cnt++;
          end
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            fail_cnt++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_tlast);
            fail_cnt++;
          end
        end
      end
    end
    results_owed = owed_q.size();
  end

endmodule

[test/json_string_unescape_tb.sv]
// Top of the json_string_unescape testbench: clock, reset, request stimulus,
// random idling on both channels, watchdog and verdict.
// Depends on jsu_pkg, json_string_unescape and json_unescape_checker.
module json_string_unescape_tb import jsu_pkg::*;;

  localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no request moving
  localparam int DRAIN_CYCLES    = 16;    // cycles to watch for stray results after the drain
  localparam int ITEMS_PER_PHASE = 108;   // four phases plus directed, about 470 requests

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tuser   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  int fail_cnt;
  int results_owed;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int stall_cycles  = 0;
  int sent          = 0;
  int goal;

  // one input request: kind travels on tuser, the byte on tdata
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } req_t;

  req_t stim_q[$];

  json_string_unescape dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] in_byte
    .in_tuser   (in_tuser),    // [0] kind
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] out_byte
    .out_tuser  (out_tuser),   // [2:0] status
    .out_tlast  (out_tlast)
  );

  json_unescape_checker checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: fresh ready decision every cycle, including during reset.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Watchdog: any cycle where neither channel moves a request counts.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  // letters legal after a backslash, \u included
  function automatic logic is_esc_letter(input logic [7:0] b);
    return b == CH_QUOTE || b == CH_BSL || b == CH_SLASH || b == CH_B || b == CH_F ||
           b == CH_N || b == CH_R || b == CH_T || b == CH_U;
  endfunction

  function automatic logic [7:0] esc_letter(input int i);
    case (i)
      0:       return CH_QUOTE;
      1:       return CH_BSL;
      2:       return CH_SLASH;
      3:       return CH_B;
      4:       return CH_F;
      5:       return CH_N;
      6:       return CH_R;
      default: return CH_T;
    endcase
  endfunction

  // ASCII hex digit for a nibble; letters come in random case
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) return 8'h30 + 8'(d);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(d) - 8'd10;
  endfunction

  // Spread code points over the one-, two- and three-byte UTF-8 forms,
  // with the range boundaries and the surrogate block picked on purpose.
  function automatic logic [15:0] rand_code_point();
    case ($urandom_range(6))
      0:       return 16'($urandom_range(16'h0000, 16'h007f));
      1:       return 16'($urandom_range(16'h0080, 16'h07ff));
      2, 3:    return 16'($urandom_range(16'h0800, 16'hffff));
      4:       return 16'($urandom_range(16'hd800, 16'hdfff));
      default: begin
        case ($urandom_range(5))
          0:       return 16'h0000;
          1:       return 16'h007f;
          2:       return 16'h0080;
          3:       return 16'h07ff;
          4:       return 16'h0800;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  task automatic push_req(input logic k, input logic [7:0] b);
    stim_q.insert(stim_q.size(), {k, b});
  endtask

  task automatic push_hex_escape(input logic [15:0] cp);
    push_req(1'b0, CH_BSL);
    push_req(1'b0, CH_U);
    push_req(1'b0, hex_char(cp[15:12]));
    push_req(1'b0, hex_char(cp[11:8]));
    push_req(1'b0, hex_char(cp[7:4]));
    push_req(1'b0, hex_char(cp[3:0]));
  endtask

  // One string body: mostly well formed with random content, closed by a quote
  // or by end of input; some strings break off with a bad escape, a bad hex
  // digit or end of input mid-escape; a few requests are pure noise.
  task automatic push_string();
    int         nseg;
    int         sel;
    logic [7:0] b;
    if ($urandom_range(99) < 8) begin
      push_req($urandom_range(99) < 10, 8'($urandom_range(255)));
      return;
    end
    nseg = $urandom_range(1, 6);
    for (int i = 0; i < nseg; i++) begin
      sel = $urandom_range(9);
      if (sel <= 3) begin
        do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSL);
        push_req(1'b0, b);
      end else if (sel <= 5) begin
        push_req(1'b0, CH_BSL);
        push_req(1'b0, esc_letter($urandom_range(7)));
      end else if (sel <= 8) begin
        push_hex_escape(rand_code_point());
      end else begin
        push_req(1'b0, CH_BSL);
        case ($urandom_range(2))
          0: begin
            do b = 8'($urandom_range(255)); while (is_esc_letter(b));
            push_req(1'b0, b);
          end
          1: begin
            push_req(1'b0, CH_U);
            repeat ($urandom_range(3)) push_req(1'b0, hex_char(4'($urandom_range(15))));
            do b = 8'($urandom_range(255)); while (is_hex(b));
            push_req(1'b0, b);
          end
          default: begin
            // end of input right after the backslash or inside the hex digits
            if ($urandom_range(1)) begin
              push_req(1'b0, CH_U);
              repeat ($urandom_range(3)) push_req(1'b0, hex_char(4'($urandom_range(15))));
            end
            push_req(1'b1, 8'($urandom_range(255)));
          end
        endcase
        return;
      end
    end
    if ($urandom_range(99) < 85) begin
      push_req(1'b0, CH_QUOTE);
    end else begin
      push_req(1'b1, 8'($urandom_range(255)));
    end
  endtask

  // Present every queued request, idling before each one at the current rate.
  // Valid stays high across back-to-back requests; it only drops on an idle cycle.
  task automatic drive_queue();
    req_t r;
    while (stim_q.size() != 0) begin
      r = stim_q.pop_front();
      while ($urandom_range(99) < in_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser  <= r.kind;
      in_tdata  <= r.data;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      sent++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, every single-letter escape, a mixed-case \u
    // escape giving three bytes, a bad escape letter, a closing quote and end
    // of input in plain text.
    push_req(1'b0, 8'h00);
    push_req(1'b0, 8'hff);
    for (int i = 0; i < 8; i++) begin
      push_req(1'b0, CH_BSL);
      push_req(1'b0, esc_letter(i));
    end
    push_req(1'b0, CH_BSL);
    push_req(1'b0, CH_U);
    push_req(1'b0, 8'h41);   // A
    push_req(1'b0, 8'h62);   // b
    push_req(1'b0, 8'h43);   // C
    push_req(1'b0, 8'h64);   // d
    push_req(1'b0, CH_BSL);
    push_req(1'b0, 8'h78);   // x: not an escape letter
    push_req(1'b0, CH_QUOTE);
    push_req(1'b1, 8'hff);
    drive_queue();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 57; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 57; end
        default: begin in_idle_pct = 32; out_stall_pct = 32; end
      endcase
      goal = sent + ITEMS_PER_PHASE;
      while (sent < goal) begin
        push_string();
        drive_queue();
      end
    end
    in_tvalid <= 1'b0;

    // Drain: every owed result must show up, then watch a while for strays.
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_emit.sv
rtl/json_string_unescape.sv
test/json_unescape_checker.sv
test/json_string_unescape_tb.sv
